FILE: hdl/pis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_pkg
// Shared types, constants and the source priority function of the
// priority interrupt selector.
// ----------------------------------------------------------------------------
package pis_pkg;

    // Pending list geometry.
    localparam int LIST_DEPTH = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Word field widths.
    localparam int SRC_W    = 5;
    localparam int MASK_W   = 2;
    localparam int HVEC_W   = 6;
    localparam int VEC_W    = 7;
    localparam int LEVEL_W  = 3;

    // Level registers, in the order of the configuration index.
    localparam int NUM_LEVELS = 7;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] LVL_IRQA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] LVL_IRQB    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] LVL_SERIAL0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] LVL_SERIAL1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] LVL_TIMER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] LVL_HOST    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] LVL_CODEC   = 3'd6;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'b111;

    localparam logic signed [LEVEL_W-1:0] PRIO_FIXED = 3'sd3;
    localparam logic signed [LEVEL_W-1:0] PRIO_OFF   = -3'sd1;

    // Special sources.
    localparam logic [SRC_W-1:0] SRC_FIXED_LAST = 5'd4;
    localparam logic [SRC_W-1:0] SRC_IRQA       = 5'd5;
    localparam logic [SRC_W-1:0] SRC_IRQB       = 5'd6;
    localparam logic [SRC_W-1:0] SRC_RESERVED   = 5'd7;
    localparam logic [SRC_W-1:0] SRC_SERIAL0_LAST = 5'd11;
    localparam logic [SRC_W-1:0] SRC_SERIAL1_LAST = 5'd15;
    localparam logic [SRC_W-1:0] SRC_TIMER_LAST   = 5'd17;
    localparam logic [SRC_W-1:0] SRC_HOST_CMD     = 5'd22;
    localparam logic [SRC_W-1:0] SRC_CODEC        = 5'd23;

    // Word kinds.
    localparam logic KIND_RAISE   = 1'b0;
    localparam logic KIND_SERVICE = 1'b1;

    typedef logic [NUM_LEVELS-1:0][LEVEL_W-1:0] t_levels;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Priority of one source under the current level registers.
    function automatic logic signed [LEVEL_W-1:0] f_src_prio(
        input logic [SRC_W-1:0] src,
        input t_levels          levels
    );
        logic signed [LEVEL_W-1:0] prio;
        if (src <= SRC_FIXED_LAST) begin
            prio = PRIO_FIXED;
        end else if (src == SRC_IRQA) begin
            prio = $signed(levels[LVL_IRQA]);
        end else if (src == SRC_IRQB) begin
            prio = $signed(levels[LVL_IRQB]);
        end else if (src == SRC_RESERVED) begin
            prio = PRIO_OFF;
        end else if (src <= SRC_SERIAL0_LAST) begin
            prio = $signed(levels[LVL_SERIAL0]);
        end else if (src <= SRC_SERIAL1_LAST) begin
            prio = $signed(levels[LVL_SERIAL1]);
        end else if (src <= SRC_TIMER_LAST) begin
            prio = $signed(levels[LVL_TIMER]);
        end else if (src == SRC_CODEC) begin
            prio = $signed(levels[LVL_CODEC]);
        end else begin
            prio = $signed(levels[LVL_HOST]);
        end
        return prio;
    endfunction

endpackage

FILE: hdl/pis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/priority_interrupt_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_interrupt_select
// Interrupt selector over 32 sources with a pending list in RAM and a
// sequential priority scan on service.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Word
// command   in         i_start, o_busy           i_kind, i_source, i_mask_level,
//                                                i_host_vector
// result    out        o_strobe (one cycle)      o_taken, o_vector,
//                                                o_clear_host_command, o_dropped
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// A raise word is finished in the accept cycle; its result strobes in the
// next cycle and o_busy never rises. A service word with pending entries
// raises o_busy for the scan, in which the single RAM read port feeds one
// entry per cycle into the shared priority compare; with an empty list it
// is answered like a raise word and o_busy stays low. The result strobes
// in the cycle in which o_busy falls. Reset is synchronous and active low;
// it empties the pending list and sets every level register to disabled.
// The result receiver cannot stall; the config port is always ready.
// ----------------------------------------------------------------------------
module priority_interrupt_select (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_kind,
    input  logic [pis_pkg::SRC_W-1:0]       i_source,
    input  logic [pis_pkg::MASK_W-1:0]      i_mask_level,
    input  logic [pis_pkg::HVEC_W-1:0]      i_host_vector,

    output logic                            o_strobe,
    output logic                            o_taken,
    output logic [pis_pkg::VEC_W-1:0]       o_vector,
    output logic                            o_clear_host_command,
    output logic                            o_dropped,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pis_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pis_pkg::LEVEL_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    pis_pkg::t_state                        r_state, n_state;
    pis_pkg::t_levels                       r_levels;
    logic [pis_pkg::CNT_W-1:0]              r_count, n_count;
    logic [pis_pkg::CNT_W-1:0]              r_addr, n_addr;
    logic                                   r_rd_vld, n_rd_vld;
    logic [pis_pkg::MASK_W-1:0]             r_mask, n_mask;
    logic [pis_pkg::HVEC_W-1:0]             r_hvec, n_hvec;
    logic                                   r_found, n_found;
    logic signed [pis_pkg::LEVEL_W-1:0]     r_best_prio, n_best_prio;
    logic [pis_pkg::SRC_W-1:0]              r_best_src, n_best_src;

    logic                                   r_strobe, n_strobe;
    logic                                   r_taken, n_taken;
    logic [pis_pkg::VEC_W-1:0]              r_vector, n_vector;
    logic                                   r_clear, n_clear;
    logic                                   r_dropped, n_dropped;

    // ------------------------------------------------------------------
    // Handshake and datapath helpers
    // ------------------------------------------------------------------
    logic                                   accept;
    logic                                   list_full;
    logic                                   ram_wr_en;
    logic                                   ram_rd_en;
    logic [pis_pkg::SRC_W-1:0]              ram_rd_data;
    logic                                   scan_done;
    logic signed [pis_pkg::LEVEL_W-1:0]     cur_prio;
    logic signed [pis_pkg::LEVEL_W-1:0]     mask_s;
    logic                                   cur_wins;

    assign accept    = i_start && (r_state == pis_pkg::ST_IDLE);
    assign list_full = (r_count == pis_pkg::CNT_W'(pis_pkg::LIST_DEPTH));
    assign ram_wr_en = accept && (i_kind == pis_pkg::KIND_RAISE) && !list_full;

    // The read port walks the list from the oldest entry; a read is issued
    // while the address is below the count, and its data arrives in the
    // following cycle, flagged by r_rd_vld.
    assign ram_rd_en = (r_state == pis_pkg::ST_SCAN) && (r_addr < r_count);
    assign scan_done = (r_state == pis_pkg::ST_SCAN) && !ram_rd_en && !r_rd_vld;

    // Shared compare unit: an entry is eligible when its priority reaches
    // the mask level, and it replaces the current best on a tie, so the
    // latest arrival wins among equal priorities.
    assign cur_prio = pis_pkg::f_src_prio(ram_rd_data, r_levels);
    assign mask_s   = $signed({1'b0, r_mask});
    assign cur_wins = r_rd_vld && (cur_prio >= mask_s) &&
                      (!r_found || (cur_prio >= r_best_prio));

    pis_ram #(
        .WIDTH (pis_pkg::SRC_W),
        .DEPTH (pis_pkg::LIST_DEPTH)
    ) u_list (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_count[pis_pkg::ADDR_W-1:0]),
        .i_wr_data (i_source),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_addr[pis_pkg::ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            pis_pkg::ST_IDLE: begin
                if (accept && (i_kind == pis_pkg::KIND_SERVICE) && (r_count != '0)) begin
                    n_state = pis_pkg::ST_SCAN;
                end
            end
            pis_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = pis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pis_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and result
    // ------------------------------------------------------------------
    always_comb begin
        n_count     = r_count;
        n_addr      = r_addr;
        n_rd_vld    = 1'b0;
        n_mask      = r_mask;
        n_hvec      = r_hvec;
        n_found     = r_found;
        n_best_prio = r_best_prio;
        n_best_src  = r_best_src;
        n_strobe    = 1'b0;
        n_taken     = r_taken;
        n_vector    = r_vector;
        n_clear     = r_clear;
        n_dropped   = r_dropped;

        case (r_state)
            pis_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_kind == pis_pkg::KIND_RAISE) begin
                        // Append, or flag the word as dropped on a full list.
                        n_strobe  = 1'b1;
                        n_taken   = 1'b0;
                        n_vector  = '0;
                        n_clear   = 1'b0;
                        n_dropped = list_full;
                        if (!list_full) begin
                            n_count = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        // Nothing pending: answer at once.
                        n_strobe  = 1'b1;
                        n_taken   = 1'b0;
                        n_vector  = '0;
                        n_clear   = 1'b0;
                        n_dropped = 1'b0;
                    end else begin
                        n_addr  = '0;
                        n_mask  = i_mask_level;
                        n_hvec  = i_host_vector;
                        n_found = 1'b0;
                    end
                end
            end
            pis_pkg::ST_SCAN: begin
                if (ram_rd_en) begin
                    n_addr   = r_addr + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (cur_wins) begin
                    n_found     = 1'b1;
                    n_best_prio = cur_prio;
                    n_best_src  = ram_rd_data;
                end
                if (scan_done) begin
                    n_strobe  = 1'b1;
                    n_taken   = r_found;
                    n_dropped = 1'b0;
                    n_count   = '0;
                    if (!r_found) begin
                        n_vector = '0;
                        n_clear  = 1'b0;
                    end else if (r_best_src == pis_pkg::SRC_HOST_CMD) begin
                        n_vector = {r_hvec, 1'b0};
                        n_clear  = 1'b1;
                    end else begin
                        n_vector = {1'b0, r_best_src, 1'b0};
                        n_clear  = 1'b0;
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pis_pkg::ST_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            r_strobe <= n_strobe;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_mask      <= n_mask;
        r_hvec      <= n_hvec;
        r_best_prio <= n_best_prio;
        r_best_src  <= n_best_src;
        r_taken     <= n_taken;
        r_vector    <= n_vector;
        r_clear     <= n_clear;
        r_dropped   <= n_dropped;
    end

    // Level registers; a write to an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= {pis_pkg::NUM_LEVELS{pis_pkg::LEVEL_RESET}};
        end else if (i_cfg_valid && o_cfg_ready &&
                     (i_cfg_index < pis_pkg::CFG_IDX_W'(pis_pkg::NUM_LEVELS))) begin
            r_levels[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_cfg_ready          = 1'b1;
    assign o_busy               = (r_state != pis_pkg::ST_IDLE);
    assign o_strobe             = r_strobe;
    assign o_taken              = r_taken;
    assign o_vector             = r_vector;
    assign o_clear_host_command = r_clear;
    assign o_dropped            = r_dropped;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pis_pkg::CNT_W'(pis_pkg::LIST_DEPTH))
        else $error("pending count exceeds list depth");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((i_kind == pis_pkg::KIND_RAISE) || (r_count == '0))) |=> o_strobe)
        else $error("raise or empty service gave no result in the next cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_state == pis_pkg::ST_IDLE))
        else $error("result strobe while a scan is running");

    a_clear_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_clear_host_command) |-> (o_taken && !o_dropped))
        else $error("host command clear without a taken interrupt");

    a_list_emptied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |=> (r_count == '0))
        else $error("pending list not emptied after service");

endmodule
